@@ src/lton_pkg.sv @@
// Shared types, constants and the helper function of the lightmap texel normalizer.
package lton_pkg;

  // Register stages between input acceptance and the output register, inclusive.
  localparam int NSTAGE = 7;
  // Restoring divider stages, two quotient bits each.
  localparam int NDIV   = 4;

  localparam logic [7:0] FULL = 8'd255;
  // floor(x / 3) == (x * THIRD_MUL) >> THIRD_SHIFT for every channel sum up to 765.
  localparam logic [9:0] THIRD_MUL   = 10'd683;
  localparam int         THIRD_SHIFT = 11;

  typedef enum logic [1:0] {
    MODE_COLOR = 2'd0,
    MODE_LUM   = 2'd1,
    MODE_FAKE  = 2'd2,
    MODE_ALPHA = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    CFG_SHIFT  = 2'd0,
    CFG_MODE   = 2'd1,
    CFG_ABSENT = 2'd2,
    CFG_SPARE  = 2'd3
  } cfg_index_t;

  // Payload that travels through the divider stages.
  typedef struct packed {
    logic [2:0][7:0] pass;    // shifted channels, valid when no rescale is needed
    logic [7:0]      apass;   // brightest shifted channel, same condition
    logic            rescale;
    logic [7:0]      dvsr;    // brightest unshifted channel
    logic [2:0][7:0] rem;
    logic [2:0][7:0] nlo;     // numerator bits not yet brought down, MSB first
    logic [2:0][7:0] quo;
  } lton_div_t;

  // Payload between the select stage and the mono stage.
  typedef struct packed {
    logic [2:0][7:0] chan;
    logic [7:0]      alpha;
    logic [7:0]      fake_alpha;
  } lton_sel_t;

  // One restoring division step on all three channels.
  function automatic lton_div_t div_step(input lton_div_t s);
    lton_div_t  t;
    logic [8:0] trial;
    t = s;
    for (int ch = 0; ch < 3; ch++) begin
      trial = {s.rem[ch], s.nlo[ch][7]};
      if (trial >= {1'b0, s.dvsr}) begin
        t.rem[ch] = 8'(trial - {1'b0, s.dvsr});
        t.quo[ch] = {s.quo[ch][6:0], 1'b1};
      end else begin
        t.rem[ch] = trial[7:0];
        t.quo[ch] = {s.quo[ch][6:0], 1'b0};
      end
      t.nlo[ch] = {s.nlo[ch][6:0], 1'b0};
    end
    return t;
  endfunction

endpackage

@@ src/lton_front.sv @@
// First stage: source select, overbright shift, maximum and divider setup.
module lton_front (
  input  logic                clk,
  input  logic                en,
  input  logic [2:0]          shift,
  input  logic                absent,
  input  logic [7:0]          red_in,
  input  logic [7:0]          green_in,
  input  logic [7:0]          blue_in,
  output lton_pkg::lton_div_t q
);
  import lton_pkg::*;

  logic [2:0][7:0]  src;
  logic [2:0][14:0] shifted;
  logic [2:0]       eff_shift;
  logic [14:0]      mx_sh;
  logic [7:0]       mx_src;
  logic [15:0]      num;
  lton_div_t        d;

  always_comb begin
    eff_shift = absent ? 3'd0 : shift;
    src[0] = absent ? FULL : red_in;
    src[1] = absent ? FULL : green_in;
    src[2] = absent ? FULL : blue_in;
    for (int ch = 0; ch < 3; ch++) begin
      shifted[ch] = {7'd0, src[ch]} << eff_shift;
    end
    mx_sh  = (shifted[0] > shifted[1]) ? shifted[0] : shifted[1];
    mx_sh  = (shifted[2] > mx_sh) ? shifted[2] : mx_sh;
    mx_src = (src[0] > src[1]) ? src[0] : src[1];
    mx_src = (src[2] > mx_src) ? src[2] : mx_src;

    // The common power of two cancels, so the rescale divides the unshifted
    // channel times 255 by the unshifted maximum.
    d.rescale = (mx_sh > 15'(FULL));
    d.apass   = mx_sh[7:0];
    d.dvsr    = mx_src;
    num       = 16'd0;
    for (int ch = 0; ch < 3; ch++) begin
      d.pass[ch] = shifted[ch][7:0];
      num        = {src[ch], 8'd0} - {8'd0, src[ch]};
      d.rem[ch]  = num[15:8];
      d.nlo[ch]  = num[7:0];
      d.quo[ch]  = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= d;
    end
  end

endmodule

@@ src/lton_div.sv @@
// One divider stage: two restoring division steps on all three channels.
module lton_div (
  input  logic                clk,
  input  logic                en,
  input  lton_pkg::lton_div_t d,
  output lton_pkg::lton_div_t q
);
  import lton_pkg::*;

  lton_div_t q_next;

  always_comb begin
    q_next = div_step(div_step(d));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= q_next;
    end
  end

endmodule

@@ src/lton_sel.sv @@
// Selects rescaled or plain channels and forms the fake-colour alpha.
module lton_sel (
  input  logic                clk,
  input  logic                en,
  input  lton_pkg::lton_div_t d,
  output lton_pkg::lton_sel_t q
);
  import lton_pkg::*;

  lton_sel_t   q_next;
  logic [9:0]  sum;
  logic [19:0] third;

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      q_next.chan[ch] = d.rescale ? d.quo[ch] : d.pass[ch];
    end
    // After a rescale the brightest channel lands exactly on 255.
    q_next.alpha = d.rescale ? FULL : d.apass;
    sum   = {2'd0, q_next.chan[0]} + {2'd0, q_next.chan[1]} + {2'd0, q_next.chan[2]};
    third = sum * THIRD_MUL;
    q_next.fake_alpha = FULL - third[THIRD_SHIFT +: 8];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= q_next;
    end
  end

endmodule

@@ src/lton_mono.sv @@
// Output stage: applies the mono mode and holds the result beat.
module lton_mono (
  input  logic                clk,
  input  logic                en,
  input  lton_pkg::mode_t     mode,
  input  lton_pkg::lton_sel_t d,
  output logic [7:0]          red_out,
  output logic [7:0]          green_out,
  output logic [7:0]          blue_out,
  output logic [7:0]          alpha_out
);
  import lton_pkg::*;

  logic [2:0][15:0] prod;
  logic [2:0][16:0] adj;
  logic [2:0][7:0]  faded;
  logic [2:0][7:0]  chan_next;
  logic [7:0]       alpha_next;

  always_comb begin
    // floor(p / 255) for a 16-bit product, without a divider.
    for (int ch = 0; ch < 3; ch++) begin
      prod[ch]  = d.chan[ch] * d.fake_alpha;
      adj[ch]   = {1'b0, prod[ch]} + 17'd1 + {9'd0, prod[ch][15:8]};
      faded[ch] = adj[ch][15:8];
    end

    unique case (mode)
      MODE_COLOR: begin
        chan_next  = d.chan;
        alpha_next = d.alpha;
      end
      MODE_LUM: begin
        chan_next  = {8'd0, 8'd0, d.alpha};
        alpha_next = d.alpha;
      end
      MODE_FAKE: begin
        chan_next  = faded;
        alpha_next = d.fake_alpha;
      end
      MODE_ALPHA: begin
        chan_next  = '0;
        alpha_next = FULL - d.alpha;
      end
      default: begin
        chan_next  = '0;
        alpha_next = FULL - d.alpha;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      red_out   <= chan_next[0];
      green_out <= chan_next[1];
      blue_out  <= chan_next[2];
      alpha_out <= alpha_next;
    end
  end

endmodule

@@ src/lightmap_texel_overbright_normalize.sv @@
// Top level of the lightmap texel overbright normalizer.
// Turns one RGB lightmap texel into one RGBA texel: overbright shift, rescale of
// texels brighter than 255 by floor(v*255/max), then the mono mode. The block
// is a seven-stage pipeline (setup, four radix-2 divider stages of two quotient
// bits each, select, mono/output register), and a new texel is taken every
// cycle unless the pipeline is full and its output stalled. Each stage holds
// only while the stage after it is full and held, so empty slots close up and
// input beats keep being taken on a stalled output until every stage is full.
// Configuration writes are taken every cycle; they should only be made while
// no texel is in flight. Indexes with no register are ignored.
module lightmap_texel_overbright_normalize (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] red_in,
  input  logic [7:0] green_in,
  input  logic [7:0] blue_in,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] red_out,
  output logic [7:0] green_out,
  output logic [7:0] blue_out,
  output logic [7:0] alpha_out,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [2:0] cfg_data
);
  import lton_pkg::*;

  logic [2:0]        overbright_shift;
  mode_t             mono_mode;
  logic              source_absent;

  logic [NSTAGE-1:0] valid;
  logic [NSTAGE-1:0] en;
  lton_div_t         div_q [0:NDIV];
  lton_sel_t         sel_q;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      overbright_shift <= 3'd0;
      mono_mode        <= MODE_COLOR;
      source_absent    <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_SHIFT:  overbright_shift <= cfg_data;
        CFG_MODE:   mono_mode        <= mode_t'(cfg_data[1:0]);
        CFG_ABSENT: source_absent    <= cfg_data[0];
        CFG_SPARE:  ;
        default:    ;
      endcase
    end
  end

  // A stage loads when it is empty or when the stage after it moves on.
  always_comb begin
    en[NSTAGE-1] = !valid[NSTAGE-1] || !out_stall;
    for (int i = NSTAGE - 2; i >= 0; i--) begin
      en[i] = !valid[i] || en[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (en[0]) begin
        valid[0] <= in_valid;
      end
      for (int i = 1; i < NSTAGE; i++) begin
        if (en[i]) begin
          valid[i] <= valid[i-1];
        end
      end
    end
  end

  assign in_stall  = !en[0];
  assign out_valid = valid[NSTAGE-1];

  lton_front u_front (
    .clk      (clk),
    .en       (en[0]),
    .shift    (overbright_shift),
    .absent   (source_absent),
    .red_in   (red_in),
    .green_in (green_in),
    .blue_in  (blue_in),
    .q        (div_q[0])
  );

  for (genvar k = 0; k < NDIV; k++) begin : g_div
    lton_div u_div (
      .clk (clk),
      .en  (en[k+1]),
      .d   (div_q[k]),
      .q   (div_q[k+1])
    );
  end

  lton_sel u_sel (
    .clk (clk),
    .en  (en[NDIV+1]),
    .d   (div_q[NDIV]),
    .q   (sel_q)
  );

  lton_mono u_mono (
    .clk       (clk),
    .en        (en[NSTAGE-1]),
    .mode      (mono_mode),
    .d         (sel_q),
    .red_out   (red_out),
    .green_out (green_out),
    .blue_out  (blue_out),
    .alpha_out (alpha_out)
  );

endmodule
